// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the resampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SLR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define SLR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/slr_pkg.sv =====
// Shared constants of the segment linear resampler.
package slr_pkg;

  localparam int LengthBitsDefault = 15;
  localparam int SampleBits        = 8;

  // Command codes carried in tuser of the input channel.
  localparam logic CMD_BEGIN  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage

// ===== src/segment_linear_resampler_unit.sv =====
// Segment linear resampler: stretches or squeezes a segment of signed samples by one sample.
//
// Input channel (s_axis): tuser is the command. A begin item carries the raw flag,
// the source count S and the target count T in tdata and produces no result. A
// sample item carries one signed 8-bit source sample and yields zero, one or two
// output items. Output channel (m_axis): tdata is the output sample, tlast marks
// the last output item of the segment.
// Raw segments, segments with S equal to T or to zero and lengths that differ by
// more than one pass each sample through. Otherwise output k sits at k*(S-1)/(T-1)
// and is interpolated between the two neighboring samples, rounded to nearest, ties even.
// A begin item is taken straight from idle. A passthrough sample goes from idle
// to the emit step. In a resampled segment an output on a whole source position
// is emitted without interpolation, and one between positions runs an 8-step
// bit-serial shift-add multiply of the sample difference by the phase, an 8-step
// restoring division by T-1 and a rounding step before it is emitted.
// The finished item sits in an output register; the next input item is taken
// while it waits. When the receiver stalls, the block holds in its emit step
// until the output register is free. Reset empties the output register and
// leaves no segment open, so samples before the first begin are dropped.
module segment_linear_resampler_unit #(
  parameter int LENGTH_BITS = slr_pkg::LengthBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata fields from bit 0 up: raw_segment, source_count, target_count, sample_in,
  // then zero padding to whole bytes.
  input  logic [((2*LENGTH_BITS+slr_pkg::SampleBits+1+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: command.
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata fields from bit 0 up: sample_out.
  output logic [slr_pkg::SampleBits-1:0] m_axis_tdata_o,
  // tlast: segment_end.
  output logic m_axis_tlast_o
);

  import slr_pkg::*;

  localparam int L        = LENGTH_BITS;
  localparam int SB       = SampleBits;
  localparam int WW       = L + SB;
  localparam int CntBits  = $clog2(SB);
  localparam int RawLsb   = 0;
  localparam int SrcLsb   = 1;
  localparam int TgtLsb   = 1 + L;
  localparam int SmpLsb   = 1 + 2 * L;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_ROUND,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic                pass_q;      // segment passes samples through
  logic                up_q;        // target longer than source
  logic [L-1:0]        den_q;       // T-1
  logic [L-1:0]        remain_q;    // outputs still to produce
  logic [L-1:0]        pos_q;       // source samples received in this segment
  logic [L-1:0]        base_q;      // integer part of the next output position
  logic [L-1:0]        frac_q;      // fraction numerator of the next output position
  logic signed [SB-1:0] prev_q;
  logic signed [SB-1:0] cur_q;
  logic [SB-1:0]       val_q;       // next output value
  logic [1:0]          nout_q;      // outputs produced for the current sample
  logic [SB-1:0]       mag_q;       // multiplier shift register, MSB first
  logic                neg_q;       // sign of the sample difference
  logic [WW-1:0]       work_q;      // product, then remainder and quotient
  logic [CntBits-1:0]  cnt_q;
  logic                m_valid_q;
  logic [SB-1:0]       m_data_q;
  logic                m_last_q;

  // Fields of the input item.
  logic                in_raw;
  logic [L-1:0]        in_src;
  logic [L-1:0]        in_tgt;
  logic [SB-1:0]       in_smp;
  logic                pass_new;

  logic                out_free;
  logic [L:0]          need;
  logic                can_emit;
  logic [SB:0]         diff;
  logic [SB:0]         diff_mag;
  logic [WW-1:0]       mul_next;
  logic [L:0]          div_t;
  logic                div_ge;
  logic [L:0]          div_sub;
  logic [L:0]          two_r;
  logic                round_up;
  logic [SB:0]         q_round;
  logic [SB:0]         result;
  logic [L:0]          frac_inc;

  assign in_raw = s_axis_tdata_i[RawLsb];
  assign in_src = s_axis_tdata_i[SrcLsb +: L];
  assign in_tgt = s_axis_tdata_i[TgtLsb +: L];
  assign in_smp = s_axis_tdata_i[SmpLsb +: SB];

  always_comb begin
    pass_new = in_raw || (in_src == in_tgt) || (in_src == '0) ||
               ({1'b0, in_src} > ({1'b0, in_tgt} + 1'b1)) ||
               ({1'b0, in_tgt} > ({1'b0, in_src} + 1'b1));
  end

  assign out_free = !m_valid_q || m_axis_tready_i;

  // An output between positions needs the sample after its integer part.
  assign need     = {1'b0, base_q} + {{L{1'b0}}, (frac_q != '0)};
  assign can_emit = need <= {1'b0, pos_q};

  assign diff     = {cur_q[SB-1], cur_q} - {prev_q[SB-1], prev_q};
  assign diff_mag = diff[SB] ? (~diff + 1'b1) : diff;

  // One shift-add step of the multiply, difference magnitude taken MSB first.
  assign mul_next = {work_q[WW-2:0], 1'b0} +
                    (mag_q[SB-1] ? {{SB{1'b0}}, frac_q} : {WW{1'b0}});

  // One restoring division step: remainder in the upper bits, quotient shifts in below.
  assign div_t   = {work_q[WW-1:SB], work_q[SB-1]};
  assign div_ge  = div_t >= {1'b0, den_q};
  assign div_sub = div_t - {1'b0, den_q};

  // Round to nearest; on a tie pick the even final value.
  always_comb begin
    two_r    = {work_q[WW-1:SB], 1'b0};
    round_up = (two_r > {1'b0, den_q}) ||
               ((two_r == {1'b0, den_q}) && (prev_q[0] ^ work_q[0]));
    q_round  = {1'b0, work_q[SB-1:0]} + {{SB{1'b0}}, round_up};
    result   = {prev_q[SB-1], prev_q} + (neg_q ? (~q_round + 1'b1) : q_round);
  end

  assign frac_inc = {1'b0, frac_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pass_q    <= 1'b0;
      up_q      <= 1'b0;
      den_q     <= '0;
      remain_q  <= '0;
      pos_q     <= '0;
      base_q    <= '0;
      frac_q    <= '0;
      prev_q    <= '0;
      cur_q     <= '0;
      val_q     <= '0;
      nout_q    <= '0;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      work_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      // The output register fills in the emit step and empties when taken.
      if ((state_q == S_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            if (s_axis_tuser_i == CMD_BEGIN) begin
              pass_q   <= pass_new;
              up_q     <= in_tgt > in_src;
              den_q    <= in_tgt - 1'b1;
              remain_q <= in_tgt;
              pos_q    <= '0;
              base_q   <= '0;
              frac_q   <= '0;
              prev_q   <= '0;
            end else if (remain_q != '0) begin
              cur_q  <= in_smp;
              val_q  <= in_smp;
              nout_q <= '0;
              state_q <= pass_q ? S_EMIT : S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if ((remain_q == '0) || (nout_q == 2'd2) || !can_emit) begin
            prev_q  <= cur_q;
            pos_q   <= pos_q + 1'b1;
            state_q <= S_IDLE;
          end else if (frac_q == '0) begin
            // Output on a whole source position: no interpolation.
            val_q   <= (base_q == pos_q) ? cur_q : prev_q;
            state_q <= S_EMIT;
          end else begin
            mag_q   <= diff_mag[SB-1:0];
            neg_q   <= diff[SB];
            work_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          work_q <= mul_next;
          mag_q  <= {mag_q[SB-2:0], 1'b0};
          if (cnt_q == CntBits'(SB - 1)) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          work_q <= {(div_ge ? div_sub[L-1:0] : div_t[L-1:0]), work_q[SB-2:0], div_ge};
          if (cnt_q == CntBits'(SB - 1)) begin
            cnt_q   <= '0;
            state_q <= S_ROUND;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ROUND: begin
          val_q   <= result[SB-1:0];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_data_q  <= val_q;
            m_last_q  <= remain_q == {{(L-1){1'b0}}, 1'b1};
            remain_q  <= remain_q - 1'b1;
            if (pass_q) begin
              prev_q  <= cur_q;
              pos_q   <= pos_q + 1'b1;
              state_q <= S_IDLE;
            end else begin
              nout_q <= nout_q + 1'b1;
              // Step the position by (S-1)/(T-1), which is one step below or above one.
              if (up_q) begin
                if (frac_q == '0) begin
                  frac_q <= den_q - 1'b1;
                end else begin
                  frac_q <= frac_q - 1'b1;
                  base_q <= base_q + 1'b1;
                end
              end else if (frac_inc == {1'b0, den_q}) begin
                frac_q <= '0;
                base_q <= base_q + 2'd2;
              end else begin
                frac_q <= frac_inc[L-1:0];
                base_q <= base_q + 1'b1;
              end
              state_q <= S_EVAL;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== src/slr_checker.sv =====
// Port-level assertions for the segment linear resampler, bound to its top level.
`include "assert_macros.svh"

module slr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_i,
  input logic                            s_tuser_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [slr_pkg::SampleBits-1:0]  m_tdata_i,
  input logic                            m_tlast_i
);

  import slr_pkg::*;

  // A stalled output item holds its contents.
  `SLR_ASSERT_CLK(a_out_hold, clk_i, rst_ni, (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i)), "stalled output item changed")

  // Reset empties the output register by the following edge.
  `SLR_ASSERT_ALWAYS(a_reset_empty, clk_i, (!rst_ni |=> !m_tvalid_i), "output valid during reset")

  // A begin item leaves the input side ready in the cycle after it is taken.
  `SLR_ASSERT_CLK(a_begin_quick, clk_i, rst_ni, (s_tvalid_i && s_tready_i && (s_tuser_i == CMD_BEGIN)) |=> s_tready_i, "begin item stalled the input")

  // A new output item only comes out of sample processing, which blocks the input.
  `SLR_ASSERT_CLK(a_out_from_work, clk_i, rst_ni, $rose(m_tvalid_i) |-> $past(!s_tready_i), "output item appeared while idle")

endmodule

bind segment_linear_resampler_unit slr_checker u_slr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tuser_i  (s_axis_tuser_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);

// ===== tb/slr_stream_checker.sv =====
`timescale 1ns / 100ps
// Stream checker that predicts the resampler's output items and compares them.
module slr_stream_checker #(
  parameter int LENGTH_BITS = slr_pkg::LengthBitsDefault,
  parameter int DATA_W      = ((2*LENGTH_BITS+slr_pkg::SampleBits+1+7)/8)*8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [DATA_W-1:0] in_data_i,
  input  logic              in_cmd_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        out_data_i,
  input  logic              out_last_i,
  output int                mismatch_count_o,
  output int                outstanding_o
);

  typedef struct packed {
    logic signed [7:0] sample;
    logic              seg_end;
  } resampled_t;

  resampled_t expected_q[$];

  // Shadow copy of the segment state.
  logic                   passthru;
  logic [LENGTH_BITS-1:0] src_len;
  logic [LENGTH_BITS-1:0] tgt_len;
  logic [LENGTH_BITS-1:0] src_pos;
  logic [LENGTH_BITS-1:0] left_count;
  logic signed [7:0]      prev_sample;

  int mismatches;
  int out_index;

  // a + (b - a) * frac / den, rounded to nearest with ties to an even result.
  function automatic int blend_round(int a, int b, int unsigned frac, int unsigned den);
    int num;
    int q;
    int r;
    int mag;
    if (frac == 0 || den == 0) return a;
    num = (b - a) * int'(frac);
    q   = num / int'(den);
    r   = num % int'(den);
    mag = (r < 0) ? -r : r;
    if (int'(2 * mag) > int'(den) || (2 * mag == int'(den) && ((a + q) & 1) != 0))
      q += (num < 0) ? -1 : 1;
    return a + q;
  endfunction

  task automatic emit(input logic [7:0] value);
    resampled_t e;
    left_count = left_count - 1'b1;
    e.sample   = value;
    e.seg_end  = (left_count == 0);
    expected_q.push_back(e);
  endtask

  task automatic load_segment(input logic raw, input logic [LENGTH_BITS-1:0] s,
                              input logic [LENGTH_BITS-1:0] t);
    int unsigned su;
    int unsigned tu;
    su = s;
    tu = t;
    // Raw segments, a zero source count and anything that is not a one-sample stretch or squeeze go through as is.
    passthru    = raw || su == tu || su == 0 || su > tu + 1 || tu > su + 1;
    src_len     = s;
    tgt_len     = t;
    src_pos     = '0;
    left_count  = t;
    prev_sample = '0;
  endtask

  task automatic take_sample(input logic signed [7:0] cur);
    int unsigned den;
    int unsigned step;
    int unsigned j;
    int unsigned k;
    int unsigned pos;
    int unsigned base;
    int unsigned frac;
    int unsigned need;
    int          a;
    int          v;
    int          n;
    // A finished segment, or none at all, ignores its samples.
    if (left_count == 0) return;
    if (passthru) begin
      emit(cur);
    end else begin
      den  = int'(tgt_len) - 1;
      step = int'(src_len) - 1;
      j    = src_pos;
      n    = 0;
      while (left_count != 0 && n < 2) begin
        k    = int'(tgt_len) - int'(left_count);
        pos  = k * step;
        base = (den != 0) ? pos / den : 0;
        frac = (den != 0) ? pos % den : 0;
        need = base + ((frac != 0) ? 1 : 0);
        if (need > j) break;
        a = (frac == 0 && base == j) ? int'(cur) : int'(prev_sample);
        v = blend_round(a, int'(cur), frac, den);
        emit(v[7:0]);
        n++;
      end
    end
    prev_sample = cur;
    src_pos     = src_pos + 1'b1;
  endtask

  task automatic check_output();
    resampled_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("output item %0d arrived with nothing expected: sample %0d last %0b",
                 out_index, $signed(out_data_i), out_last_i);
    end else begin
      want = expected_q.pop_front();
      if (want.sample !== out_data_i || want.seg_end !== out_last_i) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output item %0d: sample exp %0d got %0d, last exp %0b got %0b",
                   out_index, want.sample, $signed(out_data_i), want.seg_end, out_last_i);
      end
    end
    out_index++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      passthru         = 1'b0;
      src_len          = '0;
      tgt_len          = '0;
      src_pos          = '0;
      left_count       = '0;
      prev_sample      = '0;
      mismatches       = 0;
      out_index        = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      // Results leave the output register, so an item accepted at this edge
      // cannot produce an output accepted at the same edge.
      if (out_valid_i && out_ready_i) check_output();
      if (in_valid_i && in_ready_i) begin
        if (in_cmd_i == slr_pkg::CMD_BEGIN)
          load_segment(in_data_i[0], in_data_i[LENGTH_BITS:1],
                       in_data_i[2*LENGTH_BITS:LENGTH_BITS+1]);
        else
          take_sample(in_data_i[2*LENGTH_BITS+8:2*LENGTH_BITS+1]);
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= expected_q.size();
    end
  end

endmodule

// ===== tb/segment_linear_resampler_unit_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench of the segment resampler: stimulus, receiver stalls and verdict.
module segment_linear_resampler_unit_tb;

  localparam int LB           = slr_pkg::LengthBitsDefault;
  localparam int DATA_W       = ((2*LB+slr_pkg::SampleBits+1+7)/8)*8;
  localparam int LEN_MAX      = (1 << LB) - 1;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT   = 5000;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_data   = '0;
  logic              in_cmd    = slr_pkg::CMD_BEGIN;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_data;
  logic              out_last;

  int mismatch_count;
  int outstanding;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit tx_steady   = 1'b0;
  bit hold_request = 1'b0;

  always #6 clk_i = ~clk_i;

  segment_linear_resampler_unit #(
    .LENGTH_BITS(LB)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_cmd),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tlast_o (out_last)
  );

  slr_stream_checker #(
    .LENGTH_BITS(LB),
    .DATA_W     (DATA_W)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .in_cmd_i        (in_cmd),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .out_last_i      (out_last),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // tdata of a begin item: raw flag, S, T; the sample field carries ignored filler.
  function automatic logic [DATA_W-1:0] begin_word(logic raw, int unsigned s, int unsigned t,
                                                   logic [7:0] filler);
    logic [DATA_W-1:0] w;
    w                    = '0;
    w[0]                 = raw;
    w[LB:1]              = s[LB-1:0];
    w[2*LB:LB+1]         = t[LB-1:0];
    w[2*LB+8:2*LB+1]     = filler;
    return w;
  endfunction

  // tdata of a sample item; the count fields carry ignored filler.
  function automatic logic [DATA_W-1:0] sample_word(logic [7:0] v, logic [63:0] filler);
    logic [DATA_W-1:0] w;
    w                = '0;
    w[2*LB:0]        = filler[2*LB:0];
    w[2*LB+8:2*LB+1] = v;
    return w;
  endfunction

  function automatic logic [7:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h7F;
    if (r < 16) return 8'h80;
    return 8'($urandom);
  endfunction

  // Sender gaps: mostly none or short, now and then a long one.
  task automatic pause_sender();
    int r;
    int gap;
    if (tx_steady || burst_left > 0) return;
    r   = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the item on the bus until the edge at which it is taken.
  task automatic offer(input logic cmd, input logic [DATA_W-1:0] w);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_begin(input logic raw, input int unsigned s, input int unsigned t,
                            input logic [7:0] filler);
    pause_sender();
    offer(slr_pkg::CMD_BEGIN, begin_word(raw, s, t, filler));
  endtask

  task automatic send_sample(input logic [7:0] v, input logic [63:0] filler);
    pause_sender();
    offer(slr_pkg::CMD_SAMPLE, sample_word(v, filler));
  endtask

  task automatic run_directed();
    // A sample with no segment open is dropped.
    send_sample(8'h7F, '0);
    // Raw segment of five sources into three outputs, then one sample too many.
    send_begin(1'b1, 5, 3, 8'h00);
    send_sample(8'h7F, '0);
    send_sample(8'h80, '0);
    send_sample(8'h01, '0);
    send_sample(8'hFF, '0);
    // Stretch 4 to 5: positions fall on quarters, so ties are rounded to even.
    send_begin(1'b0, 4, 5, 8'h00);
    send_sample(8'h00, '0);
    send_sample(8'h02, '0);
    send_sample(8'hFD, '0);
    send_sample(8'h05, '0);
    // Squeeze 3 to 2 over full-scale swings.
    send_begin(1'b0, 3, 2, 8'h00);
    send_sample(8'h7F, '0);
    send_sample(8'h80, '0);
    send_sample(8'h7F, '0);
    // Zero source count falls back to passthrough.
    send_begin(1'b0, 0, 1, 8'h00);
    send_sample(8'h80, '0);
    // Zero target count: nothing comes out.
    send_begin(1'b0, 4, 0, 8'h00);
    send_sample(8'h05, '0);
    // A single output is the first sample.
    send_begin(1'b0, 2, 1, 8'h00);
    send_sample(8'h0A, '0);
    // One source into two outputs.
    send_begin(1'b0, 1, 2, 8'h00);
    send_sample(8'hF9, '0);
    // Largest counts, each segment cut short by the next begin.
    send_begin(1'b0, LEN_MAX, LEN_MAX - 1, 8'h00);
    send_sample(8'h7F, '0);
    send_begin(1'b0, LEN_MAX - 1, LEN_MAX, 8'h00);
    send_sample(8'h80, '0);
  endtask

  task automatic run_random();
    int       count;
    int       r;
    int       s;
    int       t;
    int       n;
    bit       hold_done;
    logic     raw;
    count     = 0;
    hold_done = 1'b0;
    while (count < RANDOM_ITEMS) begin
      // Once, stall the receiver for a long stretch while items keep coming.
      if (!hold_done && count >= 400) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
        burst_left   = 80;
      end
      tx_steady = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 72) begin
        // Well-formed segment: lengths differ by one most of the time.
        s = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        case ($urandom_range(0, 4))
          0, 1:    t = s + 1;
          2, 3:    t = s - 1;
          default: t = s;
        endcase
        raw = ($urandom_range(0, 9) == 0);
        n = s;
        r = $urandom_range(0, 99);
        if (r < 10) n = $urandom_range(0, s - 1);
        else if (r < 20) n = s + $urandom_range(1, 3);
        send_begin(raw, s, t, 8'($urandom));
        repeat (n) send_sample(pick_sample(), {$urandom, $urandom});
        count += 1 + n;
      end else if (r < 84) begin
        // Long resampled segment, only its start is played.
        s = $urandom_range(2, LEN_MAX - 1);
        t = ($urandom_range(0, 1) != 0) ? s + 1 : s - 1;
        n = $urandom_range(1, 6);
        send_begin(1'b0, s, t, 8'($urandom));
        repeat (n) send_sample(pick_sample(), {$urandom, $urandom});
        count += 1 + n;
      end else if (r < 94) begin
        // Arbitrary counts across the whole field range.
        s = $urandom_range(0, LEN_MAX);
        t = $urandom_range(0, LEN_MAX);
        n = $urandom_range(0, 4);
        send_begin(1'($urandom_range(0, 1)), s, t, 8'($urandom));
        repeat (n) send_sample(pick_sample(), {$urandom, $urandom});
        count += 1 + n;
      end else begin
        // Stray samples, mostly after a finished segment.
        n = $urandom_range(1, 3);
        repeat (n) send_sample(pick_sample(), {$urandom, $urandom});
        count += n;
      end
    end
    tx_steady = 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // Let the predictor count the results of the last item before waiting on them.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    // Leave room for any stray output the block might still produce.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, stretches of steady acceptance, and one long hold-off.
  initial begin
    int r;
    int len;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 85) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          len = $urandom_range(8, 40);
        end else begin
          out_ready <= 1'b1;
          len = $urandom_range(100, 250);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too many cycles without any item moving on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
